// File: rtl/core/bsi_pkg.sv
// Shared types and constants for the broadcast shape inference block.
package bsi_pkg;

  // Fixed field geometry of the shape and result transfers.
  localparam int NUM_DIMS  = 8;
  localparam int RANK_W    = 4;
  localparam int OUT_DIM_W = 32;

  // All extents of one shape or one result, index 0 is the outermost axis.
  typedef logic [NUM_DIMS-1:0][OUT_DIM_W-1:0] dims_t;

  // One finished result as it waits in the output buffer.
  typedef struct packed {
    logic              status;
    logic [RANK_W-1:0] out_rank;
    dims_t             out_dims;
  } result_t;

endpackage

// File: rtl/core/bsi_if.sv
// Valid/ready interfaces for the shape input and the result output.
interface bsi_shape_if;
  import bsi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RANK_W-1:0]    shape_rank;
  logic [OUT_DIM_W-1:0] dim_0;
  logic [OUT_DIM_W-1:0] dim_1;
  logic [OUT_DIM_W-1:0] dim_2;
  logic [OUT_DIM_W-1:0] dim_3;
  logic [OUT_DIM_W-1:0] dim_4;
  logic [OUT_DIM_W-1:0] dim_5;
  logic [OUT_DIM_W-1:0] dim_6;
  logic [OUT_DIM_W-1:0] dim_7;
  logic                 last_shape;

  modport source (
    output valid, shape_rank, dim_0, dim_1, dim_2, dim_3, dim_4, dim_5, dim_6, dim_7,
    output last_shape,
    input  ready
  );
  modport sink (
    input  valid, shape_rank, dim_0, dim_1, dim_2, dim_3, dim_4, dim_5, dim_6, dim_7,
    input  last_shape,
    output ready
  );
endinterface

interface bsi_result_if;
  import bsi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [RANK_W-1:0]    out_rank;
  logic [OUT_DIM_W-1:0] out_dim_0;
  logic [OUT_DIM_W-1:0] out_dim_1;
  logic [OUT_DIM_W-1:0] out_dim_2;
  logic [OUT_DIM_W-1:0] out_dim_3;
  logic [OUT_DIM_W-1:0] out_dim_4;
  logic [OUT_DIM_W-1:0] out_dim_5;
  logic [OUT_DIM_W-1:0] out_dim_6;
  logic [OUT_DIM_W-1:0] out_dim_7;

  modport source (
    output valid, status, out_rank, out_dim_0, out_dim_1, out_dim_2, out_dim_3,
    output out_dim_4, out_dim_5, out_dim_6, out_dim_7,
    input  ready
  );
  modport sink (
    input  valid, status, out_rank, out_dim_0, out_dim_1, out_dim_2, out_dim_3,
    input  out_dim_4, out_dim_5, out_dim_6, out_dim_7,
    output ready
  );
endinterface

// File: rtl/core/bsi_lane.sv
// One axis lane: picks its extent from the shape and updates its master extent.
module bsi_lane #(
  parameter int AXIS = 0,
  parameter int MW   = 32
) (
  input  logic [bsi_pkg::RANK_W-1:0] rank_i,
  input  bsi_pkg::dims_t             dims_i,
  input  logic [MW-1:0]              master_i,
  output logic [MW-1:0]              master_o,
  output logic                       mismatch_o
);
  import bsi_pkg::*;

  logic              active;
  logic [RANK_W-1:0] pos;
  logic [MW-1:0]     extent;
  logic [MW-1:0]     one_val;

  assign one_val = MW'(1);

  // The lane covers the axis AXIS places from the innermost end.
  assign active = (rank_i > RANK_W'(AXIS));
  assign pos    = rank_i - RANK_W'(1) - RANK_W'(AXIS);

  // Select the C-order extent that lines up with this axis.
  always_comb begin
    extent = '0;
    for (int p = 0; p < NUM_DIMS; p++) begin
      if (pos == RANK_W'(p)) begin
        extent = extent | dims_i[p][MW-1:0];
      end
    end
  end

  // A one is skipped, a master of one is filled, anything else must match.
  always_comb begin
    master_o   = master_i;
    mismatch_o = 1'b0;
    if (active && (extent != one_val)) begin
      if (master_i == one_val) begin
        master_o = extent;
      end else if (master_i != extent) begin
        mismatch_o = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bsi_merge.sv
// Combines the lane outcomes into the next group state and the finished result.
module bsi_merge #(
  parameter int RANK_CAP = 8,
  parameter int MW       = 32
) (
  input  logic [RANK_CAP-1:0]         lane_mismatch_i,
  input  logic [RANK_CAP-1:0][MW-1:0] lane_master_i,
  input  logic                        mismatch_i,
  input  logic [bsi_pkg::RANK_W-1:0]  widest_i,
  input  logic [bsi_pkg::RANK_W-1:0]  rank_i,
  output logic                        mismatch_o,
  output logic [bsi_pkg::RANK_W-1:0]  widest_o,
  output bsi_pkg::result_t            result_o
);
  import bsi_pkg::*;

  // Sticky error and widest rank of the group so far.
  assign mismatch_o = mismatch_i | (|lane_mismatch_i);
  assign widest_o   = (rank_i > widest_i) ? rank_i : widest_i;

  // Turn the inner-first masters into outer-to-inner order, zero past the rank.
  always_comb begin
    result_o.status   = mismatch_o;
    result_o.out_rank = widest_o;
    result_o.out_dims = '0;
    for (int k = 0; k < NUM_DIMS; k++) begin
      for (int j = 0; j < RANK_CAP; j++) begin
        if ((RANK_W'(k) < widest_o) &&
            (RANK_W'(j) == widest_o - RANK_W'(1) - RANK_W'(k))) begin
          result_o.out_dims[k] = result_o.out_dims[k] | OUT_DIM_W'(lane_master_i[j]);
        end
      end
    end
  end

endmodule

// File: rtl/core/bsi_outbuf.sv
// Two-entry output buffer: a main register and a skid register for results.
module bsi_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bsi_pkg::result_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output bsi_pkg::result_t pop_data_o
);
  import bsi_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop          = main_valid_q & pop_ready_i;
  assign push_ready_o = ~skid_valid_q;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_q;

  // Refill the main register from the skid entry first, then from a new push.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: rtl/core/broadcast_shape_infer.sv
// Top level of the broadcast shape inference block.
//
// Shapes arrive on shape_i, one per transfer, each with a rank and up to
// eight extents in C order; last_shape marks the final shape of a group.
// One lane per axis checks the aligned extent against its master extent in
// the cycle of the transfer, and a merging stage folds the lane errors into
// the sticky status and tracks the widest rank. A new shape is taken every
// cycle while shape_i.ready is high, since the only dependence between
// shapes is the registered group state that the lanes update.
// On the last shape of a group the result is written into a two-entry
// output buffer, held in its main or skid register, and leaves on
// result_o from the main register. The group state is then back to all-one
// masters, rank zero and no error.
// When the receiver stalls, results wait in the buffer; shape_i.ready drops
// only while both entries are occupied, and rises again the cycle after a
// result transfer.
// Reset clears the group state and empties the output buffer; the block
// takes shapes as soon as reset is released.
module broadcast_shape_infer #(
  parameter int RANK_CAP  = 8,
  parameter int DIM_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsi_shape_if.sink    shape_i,
  bsi_result_if.source result_o
);
  import bsi_pkg::*;

  localparam int MW = (DIM_WIDTH < OUT_DIM_W) ? DIM_WIDTH : OUT_DIM_W;

  logic [RANK_CAP-1:0][MW-1:0] master_q;
  logic [RANK_CAP-1:0][MW-1:0] master_d;
  logic [RANK_CAP-1:0]         lane_mismatch;
  logic [RANK_W-1:0]           widest_q, widest_d;
  logic                        mismatch_q, mismatch_d;
  logic [RANK_W-1:0]           rank_c;
  dims_t                       dims;
  result_t                     result;
  result_t                     out_data;
  logic                        in_ready;
  logic                        accept;

  // Gather the shape extents and clamp the rank.
  assign dims   = {shape_i.dim_7, shape_i.dim_6, shape_i.dim_5, shape_i.dim_4,
                   shape_i.dim_3, shape_i.dim_2, shape_i.dim_1, shape_i.dim_0};
  assign rank_c = (shape_i.shape_rank > RANK_W'(RANK_CAP)) ? RANK_W'(RANK_CAP)
                                                           : shape_i.shape_rank;

  assign shape_i.ready = in_ready;
  assign accept        = shape_i.valid & in_ready;

  // One lane per axis, counted from the innermost end.
  for (genvar a = 0; a < RANK_CAP; a++) begin : g_lane
    bsi_lane #(
      .AXIS (a),
      .MW   (MW)
    ) u_lane (
      .rank_i     (rank_c),
      .dims_i     (dims),
      .master_i   (master_q[a]),
      .master_o   (master_d[a]),
      .mismatch_o (lane_mismatch[a])
    );
  end

  // Merge the lane outcomes and build the result.
  bsi_merge #(
    .RANK_CAP (RANK_CAP),
    .MW       (MW)
  ) u_merge (
    .lane_mismatch_i (lane_mismatch),
    .lane_master_i   (master_d),
    .mismatch_i      (mismatch_q),
    .widest_i        (widest_q),
    .rank_i          (rank_c),
    .mismatch_o      (mismatch_d),
    .widest_o        (widest_d),
    .result_o        (result)
  );

  // Group state: updated on every shape, cleared after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q   <= {RANK_CAP{MW'(1)}};
      widest_q   <= '0;
      mismatch_q <= 1'b0;
    end else if (accept) begin
      if (shape_i.last_shape) begin
        master_q   <= {RANK_CAP{MW'(1)}};
        widest_q   <= '0;
        mismatch_q <= 1'b0;
      end else begin
        master_q   <= master_d;
        widest_q   <= widest_d;
        mismatch_q <= mismatch_d;
      end
    end
  end

  // Output buffer decouples the result receiver from the shape side.
  bsi_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept & shape_i.last_shape),
    .push_data_i  (result),
    .push_ready_o (in_ready),
    .pop_valid_o  (result_o.valid),
    .pop_ready_i  (result_o.ready),
    .pop_data_o   (out_data)
  );

  // Drive the result fields.
  assign result_o.status    = out_data.status;
  assign result_o.out_rank  = out_data.out_rank;
  assign result_o.out_dim_0 = out_data.out_dims[0];
  assign result_o.out_dim_1 = out_data.out_dims[1];
  assign result_o.out_dim_2 = out_data.out_dims[2];
  assign result_o.out_dim_3 = out_data.out_dims[3];
  assign result_o.out_dim_4 = out_data.out_dims[4];
  assign result_o.out_dim_5 = out_data.out_dims[5];
  assign result_o.out_dim_6 = out_data.out_dims[6];
  assign result_o.out_dim_7 = out_data.out_dims[7];

endmodule

// File: rtl/core/bsi_checker.sv
// Port-level checks of the broadcast shape inference block, bound to the top level.
module bsi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_status_i,
  input logic [bsi_pkg::RANK_W-1:0]    out_rank_i,
  input logic [bsi_pkg::OUT_DIM_W-1:0] out_dim_0_i,
  input logic [bsi_pkg::OUT_DIM_W-1:0] out_dim_7_i
);
  import bsi_pkg::*;

  // A pending result stays offered until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result valid dropped before transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_status_i) && $stable(out_rank_i) && $stable(out_dim_0_i)
       && $stable(out_dim_7_i)))
    else $error("stalled result changed");

  // A result only appears after the transfer of a last shape.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("result without a closing shape");

  // The last extent field, out_dim_7, reads as zero unless the broadcast rank is eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_rank_i != RANK_W'(NUM_DIMS))) |-> (out_dim_7_i == '0))
    else $error("innermost unused extent not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_rank_i == '0)) |-> (out_dim_0_i == '0))
    else $error("empty-rank result has a nonzero extent");

endmodule

bind broadcast_shape_infer bsi_checker u_bsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (shape_i.valid),
  .in_ready_i   (shape_i.ready),
  .in_last_i    (shape_i.last_shape),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_rank_i   (result_o.out_rank),
  .out_dim_0_i  (result_o.out_dim_0),
  .out_dim_7_i  (result_o.out_dim_7)
);

// File: verif/bsi_broadcast_checker.sv
`timescale 1ns / 1ps
// Checker that predicts broadcast shapes from shape transfers and compares the result transfers.
module bsi_broadcast_checker #(
  parameter int RANK_CAP = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsi_shape_if  shape_i,
  bsi_result_if result_i,
  output int    err_count_o,
  output int    pending_o
);
  import bsi_pkg::*;

  // Running group state: one master extent per axis, counted from the innermost end.
  logic [OUT_DIM_W-1:0] axis_extent [NUM_DIMS];
  logic [RANK_W-1:0]    widest_rank;
  logic                 axis_clash;

  // Broadcast shapes still waiting for their result transfer.
  result_t bcast_q [$];
  int      mismatches = 0;

  task automatic clear_group();
    foreach (axis_extent[i]) axis_extent[i] = 1;
    widest_rank = '0;
    axis_clash  = 1'b0;
  endtask

  // Fold one shape into the group; the last shape closes the group and queues its result.
  task automatic fold_shape(input logic [RANK_W-1:0] rank_in, input dims_t ext, input logic last);
    int                   eff;
    logic [OUT_DIM_W-1:0] d;
    result_t              res;
    eff = (rank_in > RANK_CAP) ? RANK_CAP : int'(rank_in);
    if (eff > widest_rank) widest_rank = RANK_W'(eff);
    for (int a = 0; a < eff; a++) begin
      d = ext[eff-1-a];
      if (d != 1) begin
        if (axis_extent[a] == 1) begin
          axis_extent[a] = d;
        end else if (axis_extent[a] != d) begin
          axis_clash = 1'b1;
        end
      end
    end
    if (last) begin
      res.status   = axis_clash;
      res.out_rank = widest_rank;
      for (int k = 0; k < NUM_DIMS; k++) begin
        res.out_dims[k] = (k < widest_rank) ? axis_extent[widest_rank-1-k] : '0;
      end
      bcast_q.push_back(res);
      clear_group();
    end
  endtask

  task automatic check_field(input string name, input logic [OUT_DIM_W-1:0] want,
                             input logic [OUT_DIM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the shape of the same edge is folded in, since a group
  // closed at this edge cannot have its result out yet.
  always @(posedge clk_i) begin : monitor
    dims_t   in_dims;
    dims_t   got_dims;
    result_t want;
    if (!rst_ni) begin
      clear_group();
      bcast_q.delete();
    end else begin
      if (result_i.valid && result_i.ready) begin
        got_dims[0] = result_i.out_dim_0;
        got_dims[1] = result_i.out_dim_1;
        got_dims[2] = result_i.out_dim_2;
        got_dims[3] = result_i.out_dim_3;
        got_dims[4] = result_i.out_dim_4;
        got_dims[5] = result_i.out_dim_5;
        got_dims[6] = result_i.out_dim_6;
        got_dims[7] = result_i.out_dim_7;
        if (bcast_q.size() == 0) begin
          $error("result transfer with no broadcast shape pending");
          mismatches++;
        end else begin
          want = bcast_q.pop_front();
          check_field("status", want.status, result_i.status);
          check_field("out_rank", want.out_rank, result_i.out_rank);
          for (int k = 0; k < NUM_DIMS; k++) begin
            check_field($sformatf("out_dim_%0d", k), want.out_dims[k], got_dims[k]);
          end
        end
      end
      if (shape_i.valid && shape_i.ready) begin
        in_dims[0] = shape_i.dim_0;
        in_dims[1] = shape_i.dim_1;
        in_dims[2] = shape_i.dim_2;
        in_dims[3] = shape_i.dim_3;
        in_dims[4] = shape_i.dim_4;
        in_dims[5] = shape_i.dim_5;
        in_dims[6] = shape_i.dim_6;
        in_dims[7] = shape_i.dim_7;
        fold_shape(shape_i.shape_rank, in_dims, shape_i.last_shape);
      end
    end
    err_count_o <= mismatches;
    pending_o   <= bcast_q.size();
  end

endmodule

// File: verif/tb_broadcast_shape_infer.sv
`timescale 1ns / 1ps
// Top of the broadcast shape inference testbench: clock, reset, stimulus and verdict.
module tb_broadcast_shape_infer;
  import bsi_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_SHAPES = 1200;
  localparam int HOLD_CYCLES  = 80;

  typedef logic [OUT_DIM_W-1:0] extents_t [NUM_DIMS];

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int err_count;
  int pending_cnt;
  int cycle_count = 0;
  int shapes_sent = 0;

  // Requests from the shape sender to the result receiver, and the receiver's hold flag.
  bit hold_req   = 1'b0;
  bit rx_holding = 1'b0;
  bit rx_calm    = 1'b0;

  bsi_shape_if  shape_if ();
  bsi_result_if result_if ();

  broadcast_shape_infer i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shape_i  (shape_if),
    .result_o (result_if)
  );

  bsi_broadcast_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shape_i     (shape_if),
    .result_i    (result_if),
    .err_count_o (err_count),
    .pending_o   (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Run limit, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("broadcast_shape_infer test failed");
      $finish;
    end
  end

  // Offer one shape and hold it until the transfer.
  task automatic send_shape(input int rank, input extents_t ext, input bit last);
    shape_if.valid      <= 1'b1;
    shape_if.shape_rank <= RANK_W'(rank);
    shape_if.dim_0      <= ext[0];
    shape_if.dim_1      <= ext[1];
    shape_if.dim_2      <= ext[2];
    shape_if.dim_3      <= ext[3];
    shape_if.dim_4      <= ext[4];
    shape_if.dim_5      <= ext[5];
    shape_if.dim_6      <= ext[6];
    shape_if.dim_7      <= ext[7];
    shape_if.last_shape <= last;
    @(posedge clk_i iff shape_if.ready);
    shapes_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    shape_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Extents lean toward small values so that shapes in a group meet on the same axes.
  function automatic logic [OUT_DIM_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return 1;
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  // One group: mostly shapes that broadcast to a common target, some with one wrong
  // extent, a few of pure noise. Extents past the rank carry random bits.
  task automatic send_random_group(input bit gaps_on);
    extents_t target;
    extents_t ext;
    int       tgt_rank;
    int       n_shapes;
    int       flavor;
    int       bad_shape;
    int       rk;
    int       eff;
    int       j;
    tgt_rank  = $urandom_range(0, NUM_DIMS);
    foreach (target[i]) target[i] = pick_extent();
    n_shapes  = $urandom_range(1, 4);
    flavor    = $urandom_range(0, 9);
    bad_shape = $urandom_range(0, n_shapes - 1);
    for (int s = 0; s < n_shapes; s++) begin
      if (flavor == 0) begin
        rk = $urandom_range(0, 15);
        foreach (ext[i]) ext[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
      end else begin
        rk = $urandom_range(0, tgt_rank);
        if (tgt_rank == NUM_DIMS && $urandom_range(0, 3) == 0) begin
          rk = $urandom_range(NUM_DIMS + 1, 15);
        end
        eff = (rk > NUM_DIMS) ? NUM_DIMS : rk;
        foreach (ext[i]) begin
          if (i < eff) begin
            ext[i] = ($urandom_range(0, 2) == 0) ? 32'd1 : target[tgt_rank - eff + i];
          end else begin
            ext[i] = $urandom;
          end
        end
        if (flavor <= 2 && s == bad_shape && eff > 0) begin
          j = $urandom_range(0, eff - 1);
          ext[j] = target[tgt_rank - eff + j] + $urandom_range(1, 2);
        end
      end
      if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));
      send_shape(rk, ext, s == n_shapes - 1);
    end
  endtask

  // Result receiver: random stalls, one long hold-off on request, none at the end.
  initial begin : receiver
    bit hold_done;
    hold_done       = 1'b0;
    result_if.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_holding      <= 1'b1;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_holding <= 1'b0;
      end else if (rx_calm) begin
        result_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    extents_t ext;
    shape_if.valid      = 1'b0;
    shape_if.shape_rank = '0;
    shape_if.dim_0      = '0;
    shape_if.dim_1      = '0;
    shape_if.dim_2      = '0;
    shape_if.dim_3      = '0;
    shape_if.dim_4      = '0;
    shape_if.dim_5      = '0;
    shape_if.dim_6      = '0;
    shape_if.dim_7      = '0;
    shape_if.last_shape = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scalars only: rank zero, extents ignored.
    send_shape(0, '{default: '1}, 1'b0);
    send_shape(0, '{default: '0}, 1'b1);
    // A single shape passes through unchanged.
    send_shape(2, '{3, 4, 0, 0, 0, 0, 0, 0}, 1'b1);
    // Classic broadcast of different ranks with ones on both sides.
    send_shape(4, '{8, 1, 6, 1, 0, 0, 0, 0}, 1'b0);
    send_shape(3, '{7, 1, 5, 0, 0, 0, 0, 0}, 1'b1);
    // Mismatch on the outer axis.
    send_shape(2, '{2, 3, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_shape(2, '{4, 3, 0, 0, 0, 0, 0, 0}, 1'b1);
    // Zero extent fills a master, then meets a one and a five.
    send_shape(1, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_shape(1, '{1, 0, 0, 0, 0, 0, 0, 0}, 1'b1);
    send_shape(1, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_shape(1, '{5, 0, 0, 0, 0, 0, 0, 0}, 1'b1);
    // Full rank at the largest extent, then all ones.
    send_shape(8, '{default: '1}, 1'b0);
    send_shape(8, '{default: 32'd1}, 1'b1);
    // Ranks above the maximum are clamped.
    send_shape(15, '{2, 3, 4, 5, 6, 7, 8, 9}, 1'b1);
    send_shape(9, '{default: 32'd1}, 1'b1);
    // Extents past the rank must not count.
    send_shape(1, '{7, '1, '1, '1, '1, '1, '1, '1}, 1'b0);
    send_shape(3, '{1, 1, 7, 0, 0, 0, 0, 0}, 1'b1);
    // A mismatch stays flagged after a later matching shape.
    send_shape(1, '{2, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_shape(1, '{3, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_shape(1, '{2, 0, 0, 0, 0, 0, 0, 0}, 1'b1);

    while (shapes_sent < 500) send_random_group(1'b1);

    // Long receiver hold-off while single-shape groups keep coming, so the output
    // buffer fills and the shape input stalls.
    hold_req       <= 1'b1;
    shape_if.valid <= 1'b0;
    @(posedge clk_i iff rx_holding);
    repeat (16) begin
      foreach (ext[i]) ext[i] = pick_extent();
      send_shape($urandom_range(0, 15), ext, 1'b1);
    end

    // Sender waits until every result has come.
    shape_if.valid <= 1'b0;
    @(posedge clk_i iff pending_cnt == 0);

    while (shapes_sent < 1000) send_random_group($urandom_range(0, 3) != 0);

    // Closing stretch at full rate on both sides.
    rx_calm <= 1'b1;
    while (shapes_sent < TOTAL_SHAPES) send_random_group(1'b0);

    shape_if.valid <= 1'b0;
    @(posedge clk_i iff pending_cnt == 0);
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending_cnt == 0) begin
      $display("broadcast_shape_infer test passed");
    end else begin
      $display("broadcast_shape_infer test failed");
    end
    $finish;
  end

endmodule
